[rtl/aarm_pkg.sv]
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types, constants and arithmetic helpers for the axis-angle to
// rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam logic signed [31:0] ONE_Q28     = 32'sd268435456;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;
    localparam int                 TABLE_LEN   = 24;
    localparam logic signed [15:0] UNIT_OUT    = 16'sd16384;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // back pipeline layout
    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = 29;
    localparam int DIV_FIRST    = SQRT_STAGES;
    localparam int MUL1_STAGE   = DIV_FIRST + DIV_STAGES;
    localparam int MUL2_STAGE   = MUL1_STAGE + 1;
    localparam int SUM_STAGE    = MUL2_STAGE + 1;
    localparam int PIPE_STAGES  = SUM_STAGE + 1;

    // classified request handed from front to back
    typedef struct packed {
        logic               degen;
        logic               flip;
        logic signed [31:0] ang;
        logic [31:0]        sum;
        logic [15:0]        mx;
        logic [15:0]        my;
        logic [15:0]        mz;
        logic               sx;
        logic               sy;
        logic               sz;
    } front_t;

    // one back pipeline stage
    typedef struct packed {
        logic               degen;
        logic               flip;
        logic               sx;
        logic               sy;
        logic               sz;
        logic [15:0]        mx;
        logic [15:0]        my;
        logic [15:0]        mz;
        logic [31:0]        sq_rad;
        logic [33:0]        sq_rem;
        logic [31:0]        sq_root;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [32:0]        dv_rem_x;
        logic [32:0]        dv_rem_y;
        logic [32:0]        dv_rem_z;
        logic [28:0]        q_x;
        logic [28:0]        q_y;
        logic [28:0]        q_z;
        logic signed [31:0] c;
        logic signed [31:0] t;
        logic signed [31:0] pxx;
        logic signed [31:0] pyy;
        logic signed [31:0] pzz;
        logic signed [31:0] pxy;
        logic signed [31:0] pxz;
        logic signed [31:0] pyz;
        logic signed [31:0] pxs;
        logic signed [31:0] pys;
        logic signed [31:0] pzs;
        logic [8:0][15:0]   rr;
    } stage_t;

    function automatic logic signed [31:0] atan_q28(input int i);
        logic signed [31:0] v;
        case (i)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            10:      v = 32'sd262144;
            11:      v = 32'sd131072;
            12:      v = 32'sd65536;
            13:      v = 32'sd32768;
            14:      v = 32'sd16384;
            15:      v = 32'sd8192;
            16:      v = 32'sd4096;
            17:      v = 32'sd2048;
            18:      v = 32'sd1024;
            19:      v = 32'sd512;
            20:      v = 32'sd256;
            21:      v = 32'sd128;
            22:      v = 32'sd64;
            23:      v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q.28 product, floor
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return p[59:28];
    endfunction

    // one restoring divide step: {quotient bit, new remainder}
    function automatic logic [33:0] div_step(input logic [32:0] rem,
                                             input logic [31:0] d);
        logic [32:0] sh;
        logic [32:0] dd;
        sh = {rem[31:0], 1'b0};
        dd = {1'b0, d};
        if (sh >= dd) begin
            return {1'b1, 33'(sh - dd)};
        end
        return {1'b0, sh};
    endfunction

    // round to Q1.14 and saturate
    function automatic logic [15:0] to_out(input logic signed [31:0] v);
        logic signed [32:0] w;
        logic signed [18:0] q;
        w = $signed({v[31], v}) + 33'sd8192;
        q = w[32:14];
        if (q > 19'sd16384) begin
            return UNIT_OUT;
        end
        if (q < -19'sd16384) begin
            return -UNIT_OUT;
        end
        return q[15:0];
    endfunction

endpackage

[rtl/aarm_front.sv]
// ----------------------------------------------------------------------------
// aarm_front
// Accepts requests, forms the axis length squared, folds the angle into
// -pi/2..pi/2 and flags a zero-length axis.
// ----------------------------------------------------------------------------
module aarm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic signed [15:0]   angle,
    input  logic signed [15:0]   axis_x,
    input  logic signed [15:0]   axis_y,
    input  logic signed [15:0]   axis_z,
    output logic                 q_valid,
    input  logic                 q_ready,
    output aarm_pkg::front_t     q_data
);

    logic              f_valid_reg;
    aarm_pkg::front_t  f_data_reg;
    aarm_pkg::front_t  f_data_next;

    logic signed [31:0] sqx;
    logic signed [31:0] sqy;
    logic signed [31:0] sqz;
    logic signed [31:0] ang_w;

    assign item_ready = !f_valid_reg || q_ready;
    assign q_valid    = f_valid_reg;
    assign q_data     = f_data_reg;

    always_comb
    begin
        sqx   = axis_x * axis_x;
        sqy   = axis_y * axis_y;
        sqz   = axis_z * axis_z;
        ang_w = $signed({angle[15], angle, 15'b0});
        f_data_next.sum   = 32'(sqx) + 32'(sqy) + 32'(sqz);
        f_data_next.degen = (f_data_next.sum == 32'd0);
        f_data_next.flip  = 1'b0;
        f_data_next.ang   = ang_w;
        if (ang_w > aarm_pkg::HALF_PI_Q28)
        begin
            f_data_next.ang  = ang_w - aarm_pkg::PI_Q28;
            f_data_next.flip = 1'b1;
        end
        else if (ang_w < -aarm_pkg::HALF_PI_Q28)
        begin
            f_data_next.ang  = ang_w + aarm_pkg::PI_Q28;
            f_data_next.flip = 1'b1;
        end
        f_data_next.sx = axis_x[15];
        f_data_next.sy = axis_y[15];
        f_data_next.sz = axis_z[15];
        f_data_next.mx = axis_x[15] ? 16'(-axis_x) : 16'(axis_x);
        f_data_next.my = axis_y[15] ? 16'(-axis_y) : 16'(axis_y);
        f_data_next.mz = axis_z[15] ? 16'(-axis_z) : 16'(axis_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            f_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            f_data_reg <= f_data_next;
        end
    end

endmodule

[rtl/aarm_queue.sv]
// ----------------------------------------------------------------------------
// aarm_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module aarm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  aarm_pkg::front_t  wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output aarm_pkg::front_t  rd_data
);

    aarm_pkg::front_t                 mem [aarm_pkg::QUEUE_DEPTH];
    logic [aarm_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [aarm_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [aarm_pkg::QPTR_W:0]        count_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign wr_ready = (count_reg != (aarm_pkg::QPTR_W+1)'(aarm_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/aarm_back.sv]
// ----------------------------------------------------------------------------
// aarm_back
// Pipelined square root, three dividers, CORDIC and the matrix products.
// One request per stage; the whole pipe holds while the output stalls.
// ----------------------------------------------------------------------------
module aarm_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  aarm_pkg::front_t  req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [8:0][15:0]  res_rr,
    output logic              res_degen
);

    localparam int STEPS = (CORDIC_STEPS > aarm_pkg::TABLE_LEN) ?
                           aarm_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int NST   = aarm_pkg::PIPE_STAGES;

    logic [NST-1:0]        pv_reg;
    aarm_pkg::stage_t      pipe_reg [NST];
    aarm_pkg::stage_t      nxt      [NST];
    aarm_pkg::stage_t      init_s;
    logic                  en;

    assign en        = !pv_reg[NST-1] || res_ready;
    assign req_ready = en;
    assign res_valid = pv_reg[NST-1];
    assign res_rr    = pipe_reg[NST-1].rr;
    assign res_degen = pipe_reg[NST-1].degen;

    always_comb
    begin
        init_s         = '0;
        init_s.degen   = req_data.degen;
        init_s.flip    = req_data.flip;
        init_s.sx      = req_data.sx;
        init_s.sy      = req_data.sy;
        init_s.sz      = req_data.sz;
        init_s.mx      = req_data.mx;
        init_s.my      = req_data.my;
        init_s.mz      = req_data.mz;
        init_s.sq_rad  = req_data.sum;
        init_s.cx      = aarm_pkg::GAIN_Q28;
        init_s.cy      = '0;
        init_s.cz      = req_data.ang;
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        aarm_pkg::stage_t    prv;
        aarm_pkg::stage_t    s;
        logic [35:0]         sq_t;
        logic [35:0]         sq_trial;
        logic [33:0]         dr_x;
        logic [33:0]         dr_y;
        logic [33:0]         dr_z;
        logic signed [31:0]  dx;
        logic signed [31:0]  dy;
        logic signed [31:0]  ux;
        logic signed [31:0]  uy;
        logic signed [31:0]  uz;
        logic signed [31:0]  sn;

        if (k == 0)
        begin : g_first
            assign prv = init_s;
        end
        else
        begin : g_rest
            assign prv = pipe_reg[k-1];
        end

        always_comb
        begin
            s        = prv;
            sq_t     = '0;
            sq_trial = '0;
            dr_x     = '0;
            dr_y     = '0;
            dr_z     = '0;
            dx       = '0;
            dy       = '0;
            ux       = '0;
            uy       = '0;
            uz       = '0;
            sn       = '0;
            // square root, one result bit per stage
            if (k < aarm_pkg::SQRT_STAGES)
            begin
                sq_t     = {s.sq_rem, s.sq_rad[31:30]};
                sq_trial = {2'b00, s.sq_root, 2'b01};
                if (sq_t >= sq_trial)
                begin
                    s.sq_rem  = 34'(sq_t - sq_trial);
                    s.sq_root = {s.sq_root[30:0], 1'b1};
                end
                else
                begin
                    s.sq_rem  = sq_t[33:0];
                    s.sq_root = {s.sq_root[30:0], 1'b0};
                end
                s.sq_rad = {s.sq_rad[29:0], 2'b00};
            end
            // CORDIC rotation, one micro-rotation per stage
            if (k < STEPS)
            begin
                dx = s.cy >>> k;
                dy = s.cx >>> k;
                if (!s.cz[31])
                begin
                    s.cx = s.cx - dx;
                    s.cy = s.cy + dy;
                    s.cz = s.cz - aarm_pkg::atan_q28(k);
                end
                else
                begin
                    s.cx = s.cx + dx;
                    s.cy = s.cy - dy;
                    s.cz = s.cz + aarm_pkg::atan_q28(k);
                end
            end
            // unit vector: |a| * 2^44 / r, one quotient bit per stage
            if (k == aarm_pkg::DIV_FIRST)
            begin
                s.dv_rem_x = {2'b00, s.mx, 15'b0};
                s.dv_rem_y = {2'b00, s.my, 15'b0};
                s.dv_rem_z = {2'b00, s.mz, 15'b0};
                s.q_x      = '0;
                s.q_y      = '0;
                s.q_z      = '0;
            end
            if (k >= aarm_pkg::DIV_FIRST && k < aarm_pkg::MUL1_STAGE)
            begin
                dr_x       = aarm_pkg::div_step(s.dv_rem_x, s.sq_root);
                dr_y       = aarm_pkg::div_step(s.dv_rem_y, s.sq_root);
                dr_z       = aarm_pkg::div_step(s.dv_rem_z, s.sq_root);
                s.dv_rem_x = dr_x[32:0];
                s.dv_rem_y = dr_y[32:0];
                s.dv_rem_z = dr_z[32:0];
                s.q_x      = {s.q_x[27:0], dr_x[33]};
                s.q_y      = {s.q_y[27:0], dr_y[33]};
                s.q_z      = {s.q_z[27:0], dr_z[33]};
            end
            // pairwise axis products and axis * sine
            if (k == aarm_pkg::MUL1_STAGE)
            begin
                ux    = s.sx ? -$signed({3'b000, s.q_x}) : $signed({3'b000, s.q_x});
                uy    = s.sy ? -$signed({3'b000, s.q_y}) : $signed({3'b000, s.q_y});
                uz    = s.sz ? -$signed({3'b000, s.q_z}) : $signed({3'b000, s.q_z});
                s.c   = s.flip ? -s.cx : s.cx;
                sn    = s.flip ? -s.cy : s.cy;
                s.t   = aarm_pkg::ONE_Q28 - s.c;
                s.pxx = aarm_pkg::qmul(ux, ux);
                s.pyy = aarm_pkg::qmul(uy, uy);
                s.pzz = aarm_pkg::qmul(uz, uz);
                s.pxy = aarm_pkg::qmul(ux, uy);
                s.pxz = aarm_pkg::qmul(ux, uz);
                s.pyz = aarm_pkg::qmul(uy, uz);
                s.pxs = aarm_pkg::qmul(ux, sn);
                s.pys = aarm_pkg::qmul(uy, sn);
                s.pzs = aarm_pkg::qmul(uz, sn);
            end
            // scale by 1 - cos
            if (k == aarm_pkg::MUL2_STAGE)
            begin
                s.pxx = aarm_pkg::qmul(s.pxx, s.t);
                s.pyy = aarm_pkg::qmul(s.pyy, s.t);
                s.pzz = aarm_pkg::qmul(s.pzz, s.t);
                s.pxy = aarm_pkg::qmul(s.pxy, s.t);
                s.pxz = aarm_pkg::qmul(s.pxz, s.t);
                s.pyz = aarm_pkg::qmul(s.pyz, s.t);
            end
            // entries, rounding, identity for a zero axis
            if (k == aarm_pkg::SUM_STAGE)
            begin
                s.rr[0] = aarm_pkg::to_out(s.c + s.pxx);
                s.rr[4] = aarm_pkg::to_out(s.c + s.pyy);
                s.rr[8] = aarm_pkg::to_out(s.c + s.pzz);
                s.rr[3] = aarm_pkg::to_out(s.pxy + s.pzs);
                s.rr[1] = aarm_pkg::to_out(s.pxy - s.pzs);
                s.rr[6] = aarm_pkg::to_out(s.pxz - s.pys);
                s.rr[2] = aarm_pkg::to_out(s.pxz + s.pys);
                s.rr[7] = aarm_pkg::to_out(s.pyz + s.pxs);
                s.rr[5] = aarm_pkg::to_out(s.pyz - s.pxs);
                if (s.degen)
                begin
                    s.rr    = '0;
                    s.rr[0] = aarm_pkg::UNIT_OUT;
                    s.rr[4] = aarm_pkg::UNIT_OUT;
                    s.rr[8] = aarm_pkg::UNIT_OUT;
                end
            end
            nxt[k] = s;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[k] <= nxt[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (en)
        begin
            pv_reg <= {pv_reg[NST-2:0], req_valid};
        end
    end

endmodule

[rtl/axis_angle_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Structure: front register, queue, then a 64-stage back pipe: 32 square-root,
// 29 divide, 3 multiply/sum.
// Throughput: one request per cycle while the result channel does not stall, set by the fully pipelined back end.
// Reset: rst_n clears all valid and queue pointers; no pending results remain.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                item_valid,
    output logic                item_ready,
    input  logic signed [15:0]  angle,
    input  logic signed [15:0]  axis_x,
    input  logic signed [15:0]  axis_y,
    input  logic signed [15:0]  axis_z,
    // result channel
    output logic                result_valid,
    input  logic                result_ready,
    output logic signed [15:0]  r00,
    output logic signed [15:0]  r01,
    output logic signed [15:0]  r02,
    output logic signed [15:0]  r10,
    output logic signed [15:0]  r11,
    output logic signed [15:0]  r12,
    output logic signed [15:0]  r20,
    output logic signed [15:0]  r21,
    output logic signed [15:0]  r22,
    output logic                degenerate_axis
);

    // front -> queue
    logic              fq_valid;
    logic              fq_ready;
    aarm_pkg::front_t  fq_data;
    // queue -> back
    logic              qb_valid;
    logic              qb_ready;
    aarm_pkg::front_t  qb_data;
    logic [8:0][15:0]  rr;

    // Front classifies each request: |axis|^2, zero-axis flag, angle fold.
    aarm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .angle      (angle),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    // Queue decouples front and back stalls.
    aarm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // Back: sqrt, normalize, CORDIC sin/cos, matrix terms. Its last stage is
    // the output register; the pipe advances whenever that register is free.
    aarm_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (qb_valid),
        .req_ready (qb_ready),
        .req_data  (qb_data),
        .res_valid (result_valid),
        .res_ready (result_ready),
        .res_rr    (rr),
        .res_degen (degenerate_axis)
    );

    assign r00 = $signed(rr[0]);
    assign r01 = $signed(rr[1]);
    assign r02 = $signed(rr[2]);
    assign r10 = $signed(rr[3]);
    assign r11 = $signed(rr[4]);
    assign r12 = $signed(rr[5]);
    assign r20 = $signed(rr[6]);
    assign r21 = $signed(rr[7]);
    assign r22 = $signed(rr[8]);

endmodule
